[hw/rtl/riv_pkg.sv]
// Shared types and constants for the radial impulse vector pipeline.
// Holds the register index codes, stage map and the per-stage word struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package riv_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadiusW  = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RootW    = 33;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned LinSteps  = 32;
  localparam int unsigned CompSteps = 31;

  localparam int unsigned StSub   = 0;
  localparam int unsigned StSq    = 1;
  localparam int unsigned StSum   = 2;
  localparam int unsigned StSqrt  = 3;
  localparam int unsigned StChk   = StSqrt + SqrtSteps;
  localparam int unsigned StLmul  = StChk + 1;
  localparam int unsigned StLadd  = StLmul + 1;
  localparam int unsigned StLdiv  = StLadd + 1;
  localparam int unsigned StFsel  = StLdiv + LinSteps;
  localparam int unsigned StCmul  = StFsel + 1;
  localparam int unsigned StCadd  = StCmul + 1;
  localparam int unsigned StCdiv  = StCadd + 1;
  localparam int unsigned StOut   = StCdiv + CompSteps;
  localparam int unsigned NStages = StOut + 1;

  typedef enum logic [CfgIdxW-1:0] {
    RegCenterX  = 3'd0,
    RegCenterY  = 3'd1,
    RegCenterZ  = 3'd2,
    RegRadius   = 3'd3,
    RegForce    = 3'd4,
    RegFalloff  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                   last;
    logic                   skip;
    logic [2:0]             dneg;
    logic [2:0][32:0]       dmag;
    logic [2:0][64:0]       sq;
    logic [65:0]            s;
    logic [RootW-1:0]       root;
    logic [34:0]            srem;
    logic [RadiusW-1:0]     diff;
    logic [62:0]            lprod;
    logic [RadiusW-1:0]     lrem;
    logic [31:0]            lq;
    logic [31:0]            fmag;
    logic                   fneg;
    logic [2:0][65:0]       cprod;
    logic [2:0][32:0]       crem;
    logic [2:0][30:0]       cq;
    logic [2:0]             ovf;
    logic                   applied;
    logic [2:0][31:0]       imp;
  } item_t;

endpackage
`default_nettype wire

[hw/rtl/radial_impulse_vector.sv]
// Radial impulse vector: pipelined offset, square root, falloff and normalize.
// Throughput one word per cycle whenever a valid result word is not held back by out_ready_i.
// The sqrt (33 stages) and the two long dividers (32 and 31 stages) set the depth.
// Reset clears valid bits and loads register defaults (radius 0.5, all else zero).
// Depends on riv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module radial_impulse_vector (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [riv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [31:0]          body_x_i,
  input  wire logic signed [31:0]          body_y_i,
  input  wire logic signed [31:0]          body_z_i,
  input  wire logic                        last_body_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             applied_o,
  output logic signed [31:0]               impulse_x_o,
  output logic signed [31:0]               impulse_y_o,
  output logic signed [31:0]               impulse_z_o,
  output logic                             batch_done_o
);

  localparam int unsigned N = riv_pkg::NStages;

  logic [2:0][31:0] center_q;
  logic [30:0]      radius_q;
  logic [31:0]      force_q;
  logic             mode_q;

  riv_pkg::item_t pipe_q [N];
  riv_pkg::item_t pipe_d [N];
  logic [N-1:0]   valid_q;
  logic           adv;
  logic [31:0]    fmag_cfg;

  assign cfg_ready_o = 1'b1;
  assign adv         = ~valid_q[N-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign fmag_cfg    = force_q[31] ? (32'd0 - force_q) : force_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      radius_q <= 31'd32768;
      force_q  <= '0;
      mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (riv_pkg::cfg_reg_e'(cfg_index_i))
        riv_pkg::RegCenterX: center_q[0] <= cfg_data_i;
        riv_pkg::RegCenterY: center_q[1] <= cfg_data_i;
        riv_pkg::RegCenterZ: center_q[2] <= cfg_data_i;
        riv_pkg::RegRadius:  radius_q    <= cfg_data_i[30:0];
        riv_pkg::RegForce:   force_q     <= cfg_data_i;
        riv_pkg::RegFalloff: mode_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[N-2:0], in_valid_i};
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  // offsets
  always_comb begin
    riv_pkg::item_t it;
    logic [2:0][31:0] body;
    logic [32:0] d;
    it = '0;
    body = {body_z_i, body_y_i, body_x_i};
    for (int c = 0; c < 3; c++) begin
      d = {body[c][31], body[c]} - {center_q[c][31], center_q[c]};
      it.dneg[c] = d[32];
      it.dmag[c] = d[32] ? (33'd0 - d) : d;
    end
    it.last = last_body_i;
    pipe_d[riv_pkg::StSub] = it;
  end

  // squares
  always_comb begin
    riv_pkg::item_t it;
    logic [65:0] p;
    it = pipe_q[riv_pkg::StSq-1];
    for (int c = 0; c < 3; c++) begin
      p = it.dmag[c] * it.dmag[c];
      it.sq[c] = p[64:0];
    end
    pipe_d[riv_pkg::StSq] = it;
  end

  // sum of squares
  always_comb begin
    riv_pkg::item_t it;
    it = pipe_q[riv_pkg::StSum-1];
    it.s    = {1'b0, it.sq[0]} + {1'b0, it.sq[1]} + {1'b0, it.sq[2]};
    it.root = '0;
    it.srem = '0;
    pipe_d[riv_pkg::StSum] = it;
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < riv_pkg::SqrtSteps; k++) begin : g_sqrt
    localparam int unsigned B = 2 * (riv_pkg::SqrtSteps - 1 - k);
    always_comb begin
      riv_pkg::item_t it;
      logic [36:0] t;
      logic [34:0] trial;
      it = pipe_q[riv_pkg::StSqrt+k-1];
      t     = {it.srem, it.s[B+1], it.s[B]};
      trial = {it.root[32:0], 2'b01};
      if (t >= {2'b00, trial}) begin
        t       = t - {2'b00, trial};
        it.root = {it.root[31:0], 1'b1};
      end else begin
        it.root = {it.root[31:0], 1'b0};
      end
      it.srem = t[34:0];
      pipe_d[riv_pkg::StSqrt+k] = it;
    end
  end

  // skip check and radius difference
  always_comb begin
    riv_pkg::item_t it;
    it = pipe_q[riv_pkg::StChk-1];
    it.skip = (it.root == '0) || (mode_q && (it.root > {2'b00, radius_q}));
    it.diff = radius_q - it.root[30:0];
    pipe_d[riv_pkg::StChk] = it;
  end

  always_comb begin
    riv_pkg::item_t it;
    it = pipe_q[riv_pkg::StLmul-1];
    it.lprod = it.diff * fmag_cfg;
    pipe_d[riv_pkg::StLmul] = it;
  end

  always_comb begin
    riv_pkg::item_t it;
    it = pipe_q[riv_pkg::StLadd-1];
    it.lprod = it.lprod + {33'd0, radius_q[30:1]};
    it.lrem  = it.lprod[62:32];
    it.lq    = '0;
    pipe_d[riv_pkg::StLadd] = it;
  end

  for (genvar k = 0; k < riv_pkg::LinSteps; k++) begin : g_ldiv
    localparam int unsigned B = riv_pkg::LinSteps - 1 - k;
    always_comb begin
      riv_pkg::item_t it;
      logic [31:0] t;
      it = pipe_q[riv_pkg::StLdiv+k-1];
      t = {it.lrem, it.lprod[B]};
      if (t >= {1'b0, radius_q}) begin
        t        = t - {1'b0, radius_q};
        it.lq[B] = 1'b1;
      end
      it.lrem = t[30:0];
      pipe_d[riv_pkg::StLdiv+k] = it;
    end
  end

  // force magnitude and sign
  always_comb begin
    riv_pkg::item_t it;
    it = pipe_q[riv_pkg::StFsel-1];
    if (mode_q) begin
      if (force_q[31]) begin
        it.fmag = (it.lq >= 32'h8000_0000) ? 32'h8000_0000 : it.lq;
      end else begin
        it.fmag = (it.lq > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : it.lq;
      end
      it.fneg = force_q[31] && (it.lq != '0);
    end else begin
      it.fmag = fmag_cfg;
      it.fneg = force_q[31];
    end
    pipe_d[riv_pkg::StFsel] = it;
  end

  always_comb begin
    riv_pkg::item_t it;
    logic [64:0] p;
    it = pipe_q[riv_pkg::StCmul-1];
    for (int c = 0; c < 3; c++) begin
      p = it.dmag[c] * it.fmag;
      it.cprod[c] = {1'b0, p};
    end
    pipe_d[riv_pkg::StCmul] = it;
  end

  always_comb begin
    riv_pkg::item_t it;
    logic [65:0] n;
    it = pipe_q[riv_pkg::StCadd-1];
    for (int c = 0; c < 3; c++) begin
      n = it.cprod[c] + {34'd0, it.root[32:1]};
      it.cprod[c] = n;
      it.ovf[c]   = n[65:31] >= {2'b00, it.root};
      it.crem[c]  = n[63:31];
      it.cq[c]    = '0;
    end
    pipe_d[riv_pkg::StCadd] = it;
  end

  for (genvar k = 0; k < riv_pkg::CompSteps; k++) begin : g_cdiv
    localparam int unsigned B = riv_pkg::CompSteps - 1 - k;
    always_comb begin
      riv_pkg::item_t it;
      logic [33:0] t;
      it = pipe_q[riv_pkg::StCdiv+k-1];
      for (int c = 0; c < 3; c++) begin
        t = {it.crem[c], it.cprod[c][B]};
        if (t >= {1'b0, it.root}) begin
          t           = t - {1'b0, it.root};
          it.cq[c][B] = 1'b1;
        end
        it.crem[c] = t[32:0];
      end
      pipe_d[riv_pkg::StCdiv+k] = it;
    end
  end

  // sign, saturate, zero the impulse of skipped bodies
  always_comb begin
    riv_pkg::item_t it;
    logic neg;
    it = pipe_q[riv_pkg::StOut-1];
    for (int c = 0; c < 3; c++) begin
      neg = it.dneg[c] ^ it.fneg;
      if (it.skip) begin
        it.imp[c] = '0;
      end else if (neg) begin
        it.imp[c] = it.ovf[c] ? 32'h8000_0000 : (32'd0 - {1'b0, it.cq[c]});
      end else begin
        it.imp[c] = it.ovf[c] ? 32'h7FFF_FFFF : {1'b0, it.cq[c]};
      end
    end
    it.applied = ~it.skip;
    pipe_d[riv_pkg::StOut] = it;
  end

  assign out_valid_o  = valid_q[N-1];
  assign applied_o    = pipe_q[N-1].applied;
  assign impulse_x_o  = pipe_q[N-1].imp[0];
  assign impulse_y_o  = pipe_q[N-1].imp[1];
  assign impulse_z_o  = pipe_q[N-1].imp[2];
  assign batch_done_o = pipe_q[N-1].last;

endmodule
`default_nettype wire
